[design/scfsi_pkg.sv]
`default_nettype none

package scfsi_pkg;

   localparam int NUM_CLASSES_DEF = 64;
   localparam int BLOCK_CAP_DEF   = 8;
   localparam int NUM_BLOCKS_DEF  = 128;

   localparam int CFG_WIDTH = 7;
   localparam logic [CFG_WIDTH-1:0] CLASS_COUNT_RESET = 7'd64;
   localparam logic [0:0] REG_CLASS_COUNT = 1'b0;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_TAKE   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

[design/scfsi_ram.sv]
`default_nettype none

module scfsi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/size_class_free_space_index.sv]
// Insert and take walk the class chain one block a cycle; remove also compares one
//   entry a cycle; a take that finds an empty class moves on to the next class.
// Throughput: one request at a time, set by the single walk/compare sequencer and the
//   one-port-per-side block, head and entry memories.
// Reset: synchronous; all classes empty, free chain in index order, class_count 64.
`default_nettype none

module size_class_free_space_index #(
   parameter int NUM_CLASSES = scfsi_pkg::NUM_CLASSES_DEF,
   parameter int BLOCK_CAP   = scfsi_pkg::BLOCK_CAP_DEF,
   parameter int NUM_BLOCKS  = scfsi_pkg::NUM_BLOCKS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // mode[1:0], size_class[7:2], address[39:8]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // status[1:0], taken_address[33:2], found_class[39:34]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int CW  = $clog2(NUM_CLASSES);
   localparam int CCW = $clog2(NUM_CLASSES + 1);
   localparam int BW  = $clog2(NUM_BLOCKS);
   localparam int LW  = $clog2(NUM_BLOCKS + 1);
   localparam int FW  = $clog2(BLOCK_CAP + 1);
   localparam int EW  = $clog2(NUM_BLOCKS * BLOCK_CAP);
   localparam int KW  = FW + LW;
   localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);
   localparam logic [FW-1:0] CAP = FW'(BLOCK_CAP);

   typedef enum logic [3:0] {
      S_IDLE, S_HEAD, S_WALK, S_CMP, S_REND, S_MOVE, S_TDATA,
      S_SHRINK, S_UNLINK, S_GRAB, S_GRAB2, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] cls_ff, cls_in;
   logic [31:0]   addr_ff, addr_in;
   logic [BW-1:0] cur_ff, cur_in;
   logic [LW-1:0] prev_ff, prev_in;
   logic [FW-1:0] pfill_ff, pfill_in;
   logic [FW-1:0] cfill_ff, cfill_in;
   logic [LW-1:0] clink_ff, clink_in;
   logic [FW-1:0] j_ff, j_in;
   logic [EW-1:0] hit_ff, hit_in;
   logic          found_ff, found_in;
   logic [LW-1:0] fh_ff, fh_in;
   logic          attach_ff, attach_in;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   tk_ff, tk_in;
   logic [5:0]    fc_ff, fc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;
   logic [scfsi_pkg::CFG_WIDTH-1:0] cc_ff;

   logic [CCW-1:0] cc_eff;
   logic           accept, cls_ok, next_ok;

   // memories
   logic          hd_we;
   logic [CW-1:0] hd_waddr, hd_raddr;
   logic [LW-1:0] hd_wdata, hd_rdata, head_word;
   logic          bk_we;
   logic [BW-1:0] bk_waddr, bk_raddr, bk_raq_ff;
   logic [KW-1:0] bk_wdata, bk_rdata, bk_word;
   logic          en_we;
   logic [EW-1:0] en_waddr, en_raddr;
   logic [31:0]   en_wdata, en_rdata;
   logic [NUM_CLASSES-1:0] hd_vld_ff;
   logic [NUM_BLOCKS-1:0]  bk_vld_ff;
   logic          hd_vq_ff, bk_vq_ff;

   logic [FW-1:0] bk_fill_raw, bk_fill;
   logic [LW-1:0] bk_link;

   function automatic logic [EW-1:0] slot(input logic [BW-1:0] blk, input logic [FW-1:0] j);
      slot = EW'(32'(blk) * 32'(BLOCK_CAP) + 32'(j));
   endfunction

   scfsi_ram #(.WIDTH(LW), .DEPTH(NUM_CLASSES)) u_head (
      .clock(clock), .wr_en(hd_we), .wr_addr(hd_waddr), .wr_data(hd_wdata),
      .rd_addr(hd_raddr), .rd_data(hd_rdata)
   );
   scfsi_ram #(.WIDTH(KW), .DEPTH(NUM_BLOCKS)) u_block (
      .clock(clock), .wr_en(bk_we), .wr_addr(bk_waddr), .wr_data(bk_wdata),
      .rd_addr(bk_raddr), .rd_data(bk_rdata)
   );
   scfsi_ram #(.WIDTH(32), .DEPTH(NUM_BLOCKS * BLOCK_CAP)) u_entry (
      .clock(clock), .wr_en(en_we), .wr_addr(en_waddr), .wr_data(en_wdata),
      .rd_addr(en_raddr), .rd_data(en_rdata)
   );

   // unwritten heads are null; unwritten blocks are empty and chained in order
   assign head_word   = hd_vq_ff ? hd_rdata : NIL;
   assign bk_word     = bk_vq_ff ? bk_rdata : {FW'(0), LW'(bk_raq_ff) + LW'(1)};
   assign bk_fill_raw = bk_word[LW +: FW];
   assign bk_fill     = (bk_fill_raw > CAP) ? CAP : bk_fill_raw;
   assign bk_link     = bk_word[LW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_vld_ff <= '0;
         bk_vld_ff <= '0;
      end else begin
         if (hd_we) hd_vld_ff[hd_waddr] <= 1'b1;
         if (bk_we) bk_vld_ff[bk_waddr] <= 1'b1;
      end
      hd_vq_ff  <= hd_vld_ff[hd_raddr];
      bk_vq_ff  <= bk_vld_ff[bk_raddr];
      bk_raq_ff <= bk_raddr;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= scfsi_pkg::CLASS_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == scfsi_pkg::REG_CLASS_COUNT) begin
         cc_ff <= csr_pwdata[scfsi_pkg::CFG_WIDTH-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == scfsi_pkg::REG_CLASS_COUNT) ?
                       32'(cc_ff) : 32'd0;

   assign cc_eff  = (32'(cc_ff) > 32'(NUM_CLASSES)) ? CCW'(NUM_CLASSES) : CCW'(cc_ff);
   assign cls_ok  = 32'(req_tdata[7:2]) < 32'(cc_eff);
   assign next_ok = (32'(cls_ff) + 32'd1) < 32'(cc_eff);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      cls_in    = cls_ff;
      addr_in   = addr_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      pfill_in  = pfill_ff;
      cfill_in  = cfill_ff;
      clink_in  = clink_ff;
      j_in      = j_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      fh_in     = fh_ff;
      attach_in = attach_ff;
      st_in     = st_ff;
      tk_in     = tk_ff;
      fc_in     = fc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      hd_raddr = cls_ff;
      hd_we    = 1'b0;
      hd_waddr = cls_ff;
      hd_wdata = NIL;
      bk_raddr = cur_ff;
      bk_we    = 1'b0;
      bk_waddr = cur_ff;
      bk_wdata = {cfill_ff, clink_ff};
      en_raddr = slot(cur_ff, j_ff);
      en_we    = 1'b0;
      en_waddr = hit_ff;
      en_wdata = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_tdata[1:0];
               cls_in   = CW'(req_tdata[7:2]);
               addr_in  = req_tdata[39:8];
               tk_in    = '0;
               fc_in    = '0;
               found_in = 1'b0;
               hd_raddr = CW'(req_tdata[7:2]);
               if (req_tdata[1:0] == scfsi_pkg::MODE_UNUSED || !cls_ok) begin
                  st_in    = scfsi_pkg::ST_INVALID;
                  state_in = S_DONE;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (head_word == NIL) begin
               unique case (mode_ff)
                  scfsi_pkg::MODE_INSERT: begin
                     if (fh_ff == NIL) begin
                        st_in    = scfsi_pkg::ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        attach_in = 1'b0;
                        state_in  = S_GRAB;
                     end
                  end
                  scfsi_pkg::MODE_TAKE: begin
                     if (next_ok) begin
                        cls_in   = cls_ff + CW'(1);
                        hd_raddr = cls_ff + CW'(1);
                        state_in = S_HEAD;
                     end else begin
                        st_in    = scfsi_pkg::ST_NOTFOUND;
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     st_in    = scfsi_pkg::ST_NOTFOUND;
                     state_in = S_DONE;
                  end
               endcase
            end else begin
               cur_in   = BW'(head_word);
               prev_in  = NIL;
               bk_raddr = BW'(head_word);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cfill_in = bk_fill;
            clink_in = bk_link;
            if (mode_ff == scfsi_pkg::MODE_REMOVE && bk_fill != '0) begin
               j_in     = '0;
               en_raddr = slot(cur_ff, '0);
               state_in = S_CMP;
            end else if (bk_link != NIL) begin
               prev_in  = LW'(cur_ff);
               pfill_in = bk_fill;
               cur_in   = BW'(bk_link);
               bk_raddr = BW'(bk_link);
            end else if (mode_ff == scfsi_pkg::MODE_REMOVE) begin
               state_in = S_REND;
            end else if (mode_ff == scfsi_pkg::MODE_INSERT) begin
               if (bk_fill < CAP) begin
                  en_we    = 1'b1;
                  en_waddr = slot(cur_ff, bk_fill);
                  bk_we    = 1'b1;
                  bk_wdata = {bk_fill + FW'(1), bk_link};
                  st_in    = scfsi_pkg::ST_OK;
                  state_in = S_DONE;
               end else if (fh_ff == NIL) begin
                  st_in    = scfsi_pkg::ST_FULL;
                  state_in = S_DONE;
               end else begin
                  attach_in = 1'b1;
                  state_in  = S_GRAB;
               end
            end else if (bk_fill == '0) begin
               if (next_ok) begin
                  cls_in   = cls_ff + CW'(1);
                  hd_raddr = cls_ff + CW'(1);
                  state_in = S_HEAD;
               end else begin
                  st_in    = scfsi_pkg::ST_NOTFOUND;
                  state_in = S_DONE;
               end
            end else begin
               en_raddr = slot(cur_ff, bk_fill - FW'(1));
               state_in = S_TDATA;
            end
         end
         S_CMP: begin
            if (en_rdata == addr_ff) begin
               hit_in   = slot(cur_ff, j_ff);
               found_in = 1'b1;
            end
            if (j_ff + FW'(1) < cfill_ff) begin
               j_in     = j_ff + FW'(1);
               en_raddr = slot(cur_ff, j_ff + FW'(1));
            end else if (clink_ff != NIL) begin
               prev_in  = LW'(cur_ff);
               pfill_in = cfill_ff;
               cur_in   = BW'(clink_ff);
               bk_raddr = BW'(clink_ff);
               state_in = S_WALK;
            end else begin
               state_in = S_REND;
            end
         end
         S_REND: begin
            if (!found_ff || cfill_ff == '0) begin
               st_in    = scfsi_pkg::ST_NOTFOUND;
               state_in = S_DONE;
            end else begin
               en_raddr = slot(cur_ff, cfill_ff - FW'(1));
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            en_we    = 1'b1;
            en_waddr = hit_ff;
            en_wdata = en_rdata;
            st_in    = scfsi_pkg::ST_OK;
            state_in = S_SHRINK;
         end
         S_TDATA: begin
            tk_in    = en_rdata;
            fc_in    = 6'(cls_ff);
            st_in    = scfsi_pkg::ST_OK;
            state_in = S_SHRINK;
         end
         S_SHRINK: begin
            bk_we = 1'b1;
            if (cfill_ff != FW'(1)) begin
               bk_wdata = {cfill_ff - FW'(1), clink_ff};
               state_in = S_DONE;
            end else begin
               // emptied tail goes to the front of the free chain
               bk_wdata = {FW'(0), fh_ff};
               fh_in    = LW'(cur_ff);
               state_in = S_UNLINK;
            end
         end
         S_UNLINK: begin
            if (prev_ff == NIL) begin
               hd_we = 1'b1;
            end else begin
               bk_we    = 1'b1;
               bk_waddr = BW'(prev_ff);
               bk_wdata = {pfill_ff, NIL};
            end
            state_in = S_DONE;
         end
         S_GRAB: begin
            bk_raddr = BW'(fh_ff);
            if (attach_ff) begin
               bk_we    = 1'b1;
               bk_wdata = {cfill_ff, fh_ff};
            end else begin
               hd_we    = 1'b1;
               hd_wdata = fh_ff;
            end
            state_in = S_GRAB2;
         end
         S_GRAB2: begin
            fh_in    = bk_link;
            bk_we    = 1'b1;
            bk_waddr = BW'(fh_ff);
            bk_wdata = {FW'(1), NIL};
            en_we    = 1'b1;
            en_waddr = slot(BW'(fh_ff), '0);
            st_in    = scfsi_pkg::ST_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {fc_ff, tk_ff, st_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fh_ff        <= fh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      cls_ff      <= cls_in;
      addr_ff     <= addr_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      pfill_ff    <= pfill_in;
      cfill_ff    <= cfill_in;
      clink_ff    <= clink_in;
      j_ff        <= j_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      attach_ff   <= attach_in;
      st_ff       <= st_in;
      tk_ff       <= tk_in;
      fc_ff       <= fc_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_taken_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1:0] != scfsi_pkg::ST_OK |-> rsp_data_ff[39:2] == '0)
      else $error("nonzero payload on failed request");
   a_fh_range: assert property (@(posedge clock) disable iff (reset)
      fh_ff <= NIL)
      else $error("free head out of range");
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(hd_we && state_ff == S_WALK))
      else $error("head written during chain walk");
   a_done_after_shrink: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UNLINK |=> state_ff == S_DONE)
      else $error("unlink did not complete");
`endif

endmodule

`default_nettype wire
